>>> design/dvs_pkg.sv
// Shared types and constants of the damped vector spring.
package dvs_pkg;

	localparam int unsigned ONE_Q16 = 65536;

	// frame_time thresholds: ft*N > 1.0 is the same as ft > floor(1.0/N)
	localparam logic [15:0] FT_SKIP = 16'(ONE_Q16 / 3);
	localparam logic [15:0] FT_30   = 16'(ONE_Q16 / 30);
	localparam logic [15:0] FT_15   = 16'(ONE_Q16 / 15);
	localparam logic [15:0] FT_10   = 16'(ONE_Q16 / 10);

	// shared datapath widths
	localparam int MUL_W  = 26;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DIV_NW = 41;
	localparam int DIV_DW = 26;
	localparam int SQ_W   = 50;
	localparam int RT_W   = SQ_W / 2;

	// |v| > 0.0001 expressed on the Q.32 sum of squares
	localparam logic [SQ_W-1:0] MOVE_SQ_THRESH = SQ_W'(42);

	localparam logic signed [23:0] MAX24 = 24'sh7FFFFF;
	localparam logic signed [23:0] MIN24 = -24'sh800000;

	localparam logic [1:0] OP_UPDATE  = 2'd0;
	localparam logic [1:0] OP_IMPULSE = 2'd1;
	localparam logic [1:0] OP_RESET   = 2'd2;
	localparam logic [1:0] OP_NOP     = 2'd3;

	localparam logic [2:0] REG_SPRING = 3'd0;
	localparam logic [2:0] REG_DAMP   = 3'd1;
	localparam logic [2:0] REG_NORM   = 3'd2;
	localparam logic [2:0] REG_LIM_LO = 3'd3;
	localparam logic [2:0] REG_LIM_HI = 3'd4;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic            start;
		logic [SQ_W-1:0] rad;
	} sq_req_t;

	typedef struct packed {
		logic            done;
		logic [RT_W-1:0] root;
	} sq_rsp_t;

endpackage

>>> design/dvs_mul.sv
// Shared signed multiplier with registered product.
module dvs_mul (
	input  logic                                clk,
	input  logic signed [dvs_pkg::MUL_W-1:0]    a,
	input  logic signed [dvs_pkg::MUL_W-1:0]    b,
	output logic signed [dvs_pkg::PROD_W-1:0]   p
);

	logic signed [dvs_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

>>> design/dvs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module dvs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  dvs_pkg::div_req_t   req,
	output dvs_pkg::div_rsp_t   rsp
);

	localparam int NW = dvs_pkg::DIV_NW;
	localparam int DW = dvs_pkg::DIV_DW;
	localparam int CW = $clog2(NW);

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   rem_sh, rem_nx;
	logic          ge;

	always_comb begin
		rem_sh = {rem_q, num_q[NW-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= rem_nx[DW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule

>>> design/dvs_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module dvs_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  dvs_pkg::sq_req_t   req,
	output dvs_pkg::sq_rsp_t   rsp
);

	localparam int SW = dvs_pkg::SQ_W;
	localparam int RW = dvs_pkg::RT_W;
	localparam int CW = $clog2(RW);
	localparam int EW = RW + 2;

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] rad_q;
	logic [RW-1:0] root_q;
	logic [EW-1:0] rem_q;
	logic [EW+1:0] rem_sh, trial, rem_nx;
	logic          ge;

	always_comb begin
		rem_sh = {rem_q, rad_q[SW-1:SW-2]};
		trial  = (EW+2)'({root_q, 2'b01});
		ge     = rem_sh >= trial;
		rem_nx = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SW-3:0], 2'b00};
			root_q <= {root_q[RW-2:0], ge};
			rem_q  <= rem_nx[EW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

>>> design/damped_vector_spring_top.sv
// Top level of the damped vector spring: sequencer, state and beat registers.
//
// Keeps a 3-axis position and velocity in signed Q7.16 and handles one beat
// at a time. Opcode in s_tuser: update (spring toward the goal over 1 to
// MAX_SUBSTEPS substeps, more substeps as frame time grows, skipped below
// 3 fps), impulse (kick to velocity, share of it to position), reset to goal.
// The serial divider is used once per update for the substep length and
// once per axis per substep, twice with normalising on. s_tready is high
// only while the sequencer is idle; one finished result may wait in the
// output register while the next beat is taken. Configuration writes are
// always accepted and must only be issued while the block is idle.
module damped_vector_spring_top #(
	parameter int MIN_SUBSTEPS = 1,
	parameter int MAX_SUBSTEPS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	// config write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data,
	// input beats
	input  logic         s_tvalid,
	output logic         s_tready,
	// frame_time, goal_x, goal_y, goal_z, kick_x, kick_y, kick_z, instant_share
	input  logic [175:0] s_tdata,
	// opcode
	input  logic [1:0]   s_tuser,
	// result beats
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y, pos_z, moving, zero pad
	output logic [79:0]  m_tdata,
	// skipped
	output logic [0:0]   m_tuser
);

	localparam int NW = $clog2(MAX_SUBSTEPS + 1);
	localparam int MW = dvs_pkg::MUL_W;
	localparam int PW = dvs_pkg::PROD_W;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_UPD   = 5'd1;
	localparam logic [4:0] ST_HDIV  = 5'd2;
	localparam logic [4:0] ST_KMUL  = 5'd3;
	localparam logic [4:0] ST_KGET  = 5'd4;
	localparam logic [4:0] ST_DMUL  = 5'd5;
	localparam logic [4:0] ST_DGET  = 5'd6;
	localparam logic [4:0] ST_FMUL  = 5'd7;
	localparam logic [4:0] ST_FGET  = 5'd8;
	localparam logic [4:0] ST_VDIV  = 5'd9;
	localparam logic [4:0] ST_PMUL  = 5'd10;
	localparam logic [4:0] ST_PGET  = 5'd11;
	localparam logic [4:0] ST_NMUL  = 5'd12;
	localparam logic [4:0] ST_NGET  = 5'd13;
	localparam logic [4:0] ST_NSQS  = 5'd14;
	localparam logic [4:0] ST_NSQW  = 5'd15;
	localparam logic [4:0] ST_NST   = 5'd16;
	localparam logic [4:0] ST_NDIV  = 5'd17;
	localparam logic [4:0] ST_CLAMP = 5'd18;
	localparam logic [4:0] ST_MMUL  = 5'd19;
	localparam logic [4:0] ST_MGET  = 5'd20;
	localparam logic [4:0] ST_IMP   = 5'd21;
	localparam logic [4:0] ST_IMUL  = 5'd22;
	localparam logic [4:0] ST_IGET  = 5'd23;
	localparam logic [4:0] ST_RST   = 5'd24;
	localparam logic [4:0] ST_DONE  = 5'd25;

	function automatic logic signed [23:0] sat24(input logic signed [36:0] v);
		if (v > 37'(dvs_pkg::MAX24))
			return dvs_pkg::MAX24;
		else if (v < 37'(dvs_pkg::MIN24))
			return dvs_pkg::MIN24;
		else
			return v[23:0];
	endfunction

	// low limit checked first; with crossed limits any value at or above it gets the high limit
	function automatic logic signed [23:0] clamp_ax(input logic signed [24:0] v,
			input logic signed [23:0] lo, input logic signed [23:0] hi);
		if (v < 25'(lo))
			return lo;
		else if (v > 25'(hi))
			return hi;
		else
			return v[23:0];
	endfunction

	// config registers
	logic        [22:0] spring_q, damp_q;
	logic               norm_q;
	logic signed [23:0] lim_lo_q, lim_hi_q;

	// architectural state
	logic signed [24:0] pos_q [0:2];
	logic signed [23:0] vel_q [0:2];
	logic               active_q;

	// latched beat
	logic        [15:0] ft_q, share_q;
	logic signed [23:0] goal_q [0:2];
	logic signed [23:0] kick_q [0:2];

	// working registers
	logic [4:0]                   state_q;
	logic [1:0]                   ax_q;
	logic [NW-1:0]                n_q, sub_q;
	logic [15:0]                  h_q;
	logic [22:0]                  k_q;
	logic [23:0]                  d_q;
	logic                         sign_q, skip_q;
	logic [dvs_pkg::SQ_W-1:0]     acc_q;
	logic [dvs_pkg::RT_W-1:0]     m_q;

	// output register
	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;
	logic        m_tuser_q;

	// shared units
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod, rp;
	dvs_pkg::div_req_t    div_req;
	dvs_pkg::div_rsp_t    div_rsp;
	dvs_pkg::sq_req_t     sq_req;
	dvs_pkg::sq_rsp_t     sq_rsp;

	logic [NW-1:0]               n_calc;
	logic signed [35:0]          force_v;
	logic signed [23:0]          vsat;
	logic signed [24:0]          vs_e, vmag, pmag, pos_sel;
	logic signed [24:0]          vq_s, pq_s;
	logic [dvs_pkg::SQ_W-1:0]    acc_nx;
	int                          n_raw;

	dvs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
	dvs_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	dvs_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sq_req), .rsp(sq_rsp));

	// substep count from the frame rate bands
	always_comb begin
		n_raw = MIN_SUBSTEPS + int'(ft_q > dvs_pkg::FT_30) + int'(ft_q > dvs_pkg::FT_15)
			+ int'(ft_q > dvs_pkg::FT_10);
		if (n_raw > MAX_SUBSTEPS)
			n_raw = MAX_SUBSTEPS;
		if (n_raw < 1)
			n_raw = 1;
		n_calc = NW'(n_raw);
	end

	// datapath around the shared units
	always_comb begin
		pos_sel = pos_q[ax_q];
		rp      = prod + PW'(32768);
		force_v = rp[51:16];
		vsat    = sat24(37'(vel_q[ax_q]) + 37'(force_v));
		vs_e    = 25'(vsat);
		vmag    = vs_e[24] ? -vs_e : vs_e;
		pmag    = pos_sel[24] ? -pos_sel : pos_sel;
		vq_s    = sign_q ? -$signed({1'b0, div_rsp.quo[23:0]})
			: $signed({1'b0, div_rsp.quo[23:0]});
		pq_s    = pos_sel[24] ? -$signed(div_rsp.quo[24:0]) : $signed(div_rsp.quo[24:0]);
		acc_nx  = acc_q + prod[dvs_pkg::SQ_W-1:0];

		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_KMUL: begin
				mul_a = $signed({3'b000, spring_q});
				mul_b = $signed({10'd0, h_q});
			end
			ST_DMUL: begin
				mul_a = $signed({3'b000, damp_q});
				mul_b = $signed({10'd0, h_q});
			end
			ST_FMUL: begin
				mul_a = $signed({3'b000, k_q});
				mul_b = 26'(goal_q[ax_q]) - 26'(pos_sel);
			end
			ST_PMUL: begin
				mul_a = 26'(vel_q[ax_q]);
				mul_b = $signed({10'd0, h_q});
			end
			ST_NMUL: begin
				mul_a = 26'(pos_sel);
				mul_b = 26'(pos_sel);
			end
			ST_MMUL: begin
				mul_a = 26'(vel_q[ax_q]);
				mul_b = 26'(vel_q[ax_q]);
			end
			ST_IMUL: begin
				mul_a = 26'(kick_q[ax_q]);
				mul_b = $signed({10'd0, share_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase

		div_req = '0;
		case (state_q)
			ST_UPD: begin
				div_req.start = !(ft_q > dvs_pkg::FT_SKIP);
				div_req.num   = dvs_pkg::DIV_NW'(ft_q);
				div_req.den   = dvs_pkg::DIV_DW'(n_calc);
			end
			ST_FGET: begin
				div_req.start = 1'b1;
				div_req.num   = {1'b0, vmag[23:0], 16'd0};
				div_req.den   = {2'b00, d_q};
			end
			ST_NST: begin
				div_req.start = 1'b1;
				div_req.num   = {pmag, 16'd0};
				div_req.den   = {1'b0, m_q};
			end
			default: div_req = '0;
		endcase

		sq_req.start = (state_q == ST_NSQS);
		sq_req.rad   = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_q   <= 23'd65536;
			damp_q     <= 23'd196608;
			norm_q     <= 1'b0;
			lim_lo_q   <= -24'sd65536;
			lim_hi_q   <= 24'sd65536;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
			active_q   <= 1'b0;
			state_q    <= ST_IDLE;
			ax_q       <= '0;
			sub_q      <= '0;
			n_q        <= '0;
			skip_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					dvs_pkg::REG_SPRING: spring_q <= cfg_data[22:0];
					dvs_pkg::REG_DAMP:   damp_q   <= cfg_data[22:0];
					dvs_pkg::REG_NORM:   norm_q   <= cfg_data[0];
					dvs_pkg::REG_LIM_LO: lim_lo_q <= $signed(cfg_data);
					dvs_pkg::REG_LIM_HI: lim_hi_q <= $signed(cfg_data);
					default: ;
				endcase
			end

			// output slot: filled by a finished result, freed by a taken beat
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ft_q      <= s_tdata[15:0];
						goal_q[0] <= $signed(s_tdata[39:16]);
						goal_q[1] <= $signed(s_tdata[63:40]);
						goal_q[2] <= $signed(s_tdata[87:64]);
						kick_q[0] <= $signed(s_tdata[111:88]);
						kick_q[1] <= $signed(s_tdata[135:112]);
						kick_q[2] <= $signed(s_tdata[159:136]);
						share_q   <= s_tdata[175:160];
						skip_q    <= 1'b0;
						ax_q      <= '0;
						case (s_tuser)
							dvs_pkg::OP_UPDATE:  state_q <= ST_UPD;
							dvs_pkg::OP_IMPULSE: state_q <= ST_IMP;
							dvs_pkg::OP_RESET:   state_q <= ST_RST;
							default:             state_q <= ST_DONE;
						endcase
					end
				end
				ST_UPD: begin
					if (ft_q > dvs_pkg::FT_SKIP) begin
						skip_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						n_q     <= n_calc;
						state_q <= ST_HDIV;
					end
				end
				ST_HDIV: begin
					if (div_rsp.done) begin
						h_q     <= div_rsp.quo[15:0];
						state_q <= ST_KMUL;
					end
				end
				ST_KMUL: state_q <= ST_KGET;
				ST_KGET: begin
					k_q     <= rp[38:16];
					state_q <= ST_DMUL;
				end
				ST_DMUL: state_q <= ST_DGET;
				ST_DGET: begin
					d_q     <= 24'(dvs_pkg::ONE_Q16) + rp[39:16];
					sub_q   <= '0;
					ax_q    <= '0;
					state_q <= ST_FMUL;
				end
				ST_FMUL: state_q <= ST_FGET;
				ST_FGET: begin
					sign_q  <= vsat[23];
					state_q <= ST_VDIV;
				end
				ST_VDIV: begin
					if (div_rsp.done) begin
						vel_q[ax_q] <= vq_s[23:0];
						state_q     <= ST_PMUL;
					end
				end
				ST_PMUL: state_q <= ST_PGET;
				ST_PGET: begin
					pos_q[ax_q] <= pos_sel + $signed(rp[40:16]);
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						acc_q   <= '0;
						state_q <= norm_q ? ST_NMUL : ST_CLAMP;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_FMUL;
					end
				end
				ST_NMUL: state_q <= ST_NGET;
				ST_NGET: begin
					acc_q <= acc_nx;
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= ST_NSQS;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_NMUL;
					end
				end
				ST_NSQS: state_q <= ST_NSQW;
				ST_NSQW: begin
					if (sq_rsp.done) begin
						m_q     <= sq_rsp.root;
						// zero length: position left as it is
						state_q <= (sq_rsp.root == '0) ? ST_CLAMP : ST_NST;
					end
				end
				ST_NST: state_q <= ST_NDIV;
				ST_NDIV: begin
					if (div_rsp.done) begin
						pos_q[ax_q] <= pq_s;
						if (ax_q == 2'd2) begin
							ax_q    <= '0;
							state_q <= ST_CLAMP;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= ST_NST;
						end
					end
				end
				ST_CLAMP: begin
					for (int i = 0; i < 3; i++)
						pos_q[i] <= 25'(clamp_ax(pos_q[i], lim_lo_q, lim_hi_q));
					ax_q <= '0;
					if (sub_q == NW'(n_q - 1'b1)) begin
						acc_q   <= '0;
						state_q <= ST_MMUL;
					end else begin
						sub_q   <= sub_q + 1'b1;
						state_q <= ST_FMUL;
					end
				end
				ST_MMUL: state_q <= ST_MGET;
				ST_MGET: begin
					acc_q <= acc_nx;
					if (ax_q == 2'd2) begin
						active_q <= acc_nx > dvs_pkg::MOVE_SQ_THRESH;
						state_q  <= ST_DONE;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_MMUL;
					end
				end
				ST_IMP: begin
					for (int i = 0; i < 3; i++)
						vel_q[i] <= sat24(37'(vel_q[i]) + 37'(kick_q[i]));
					ax_q    <= '0;
					state_q <= (share_q == '0) ? ST_DONE : ST_IMUL;
				end
				ST_IMUL: state_q <= ST_IGET;
				ST_IGET: begin
					pos_q[ax_q] <= 25'(clamp_ax(pos_sel + $signed(rp[40:16]),
						lim_lo_q, lim_hi_q));
					if (ax_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_IMUL;
					end
				end
				ST_RST: begin
					for (int i = 0; i < 3; i++) begin
						pos_q[i] <= 25'(goal_q[i]);
						vel_q[i] <= '0;
					end
					active_q <= 1'b0;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					// wait for the output slot to free up
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {7'd0, active_q, pos_q[2][23:0], pos_q[1][23:0],
							pos_q[0][23:0]};
						m_tuser_q  <= skip_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg_ready  = 1'b1;
	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	// a taken beat always starts the sequencer
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != ST_IDLE)
		else $error("accepted beat did not leave idle");

	// substep counter stays inside the chosen count
	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLAMP |-> sub_q < n_q)
		else $error("substep counter overran");

	// divider results only arrive while the sequencer waits for one
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_HDIV || state_q == ST_VDIV || state_q == ST_NDIV))
		else $error("divider finished outside a wait state");

endmodule
